### sv/ntcrt_pkg.sv
// ----------------------------------------------------------------------------
// ntcrt_pkg
// Shared types and constants of the NTC resistance to temperature converter:
// the resistance and temperature tables, queue entry and status types.
// ----------------------------------------------------------------------------
package ntcrt_pkg;

  localparam int STORED_ENTRIES = 33;
  localparam int SEG_W          = 6;    // indexes every stored entry
  localparam int RES_W          = 32;
  localparam int TEMP_W         = 12;
  localparam int DT_W           = 12;
  localparam int PROD_W         = RES_W + DT_W;
  // Quotient never exceeds the temperature step between entries (50)
  localparam int QUOT_W         = 7;
  localparam int REM_W          = PROD_W + 2;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic signed [TEMP_W-1:0] TEMP_COLD = -12'sd400;
  localparam logic signed [TEMP_W-1:0] TEMP_HOT  = 12'sd1200;

  localparam logic [RES_W-1:0] OHM_TABLE [STORED_ENTRIES] = '{
    32'd400000000, 32'd260000000, 32'd190000000, 32'd150000000, 32'd110000000,
    32'd75000000,  32'd56000000,  32'd43000000,  32'd33000000,  32'd26000000,
    32'd20000000,  32'd16000000,  32'd13000000,  32'd10000000,  32'd8200000,
    32'd6500000,   32'd5400000,   32'd4300000,   32'd3600000,   32'd3000000,
    32'd2500000,   32'd2000000,   32'd1800000,   32'd1600000,   32'd1300000,
    32'd1000000,   32'd920000,    32'd780000,    32'd650000,    32'd570000,
    32'd490000,    32'd430000,    32'd380000
  };

  localparam logic signed [TEMP_W-1:0] TEMP_TABLE [STORED_ENTRIES] = '{
    -12'sd400, -12'sd350, -12'sd300, -12'sd250, -12'sd200, -12'sd150,
    -12'sd100, -12'sd50,  12'sd0,    12'sd50,   12'sd100,  12'sd150,
    12'sd200,  12'sd250,  12'sd300,  12'sd350,  12'sd400,  12'sd450,
    12'sd500,  12'sd550,  12'sd600,  12'sd650,  12'sd700,  12'sd750,
    12'sd800,  12'sd850,  12'sd900,  12'sd950,  12'sd1000, 12'sd1050,
    12'sd1100, 12'sd1150, 12'sd1200
  };

  typedef enum logic [1:0] {
    CLS_COLD,
    CLS_HOT,
    CLS_INTERP
  } cls_t;

  typedef struct packed {
    cls_t             cls;
    logic [SEG_W-1:0] seg;
    logic [RES_W-1:0] resistance;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_OUT
  } bk_state_t;

endpackage

### sv/ntcrt_in_if.sv
// ----------------------------------------------------------------------------
// ntcrt_in_if
// Input channel: thermistor resistance sample with wiring fault flags.
// ----------------------------------------------------------------------------
interface ntcrt_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] resistance_milliohm;
  logic        line_open_fault;
  logic        line_short_fault;

  modport source (output valid, output resistance_milliohm, output line_open_fault,
                  output line_short_fault, input ready);
  modport sink   (input valid, input resistance_milliohm, input line_open_fault,
                  input line_short_fault, output ready);
endinterface

### sv/ntcrt_out_if.sv
// ----------------------------------------------------------------------------
// ntcrt_out_if
// Result channel: temperature in tenths of a degree, two's complement.
// ----------------------------------------------------------------------------
interface ntcrt_out_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] temperature_decidegree;

  modport source (output valid, output temperature_decidegree, input ready);
  modport sink   (input valid, input temperature_decidegree, output ready);
endinterface

### sv/ntcrt_front.sv
// ----------------------------------------------------------------------------
// ntcrt_front
// Accepts samples, decides cold / hot / interpolate and finds the table
// segment that brackets the resistance.
// ----------------------------------------------------------------------------
module ntcrt_front #(
  parameter int USED_ENTRIES = 33
) (
  input  logic                clk,
  input  logic                rst_n,
  ntcrt_in_if.sink            in_ch,
  output logic                push_valid,
  input  logic                push_ready,
  output ntcrt_pkg::q_entry_t push_entry
);
  import ntcrt_pkg::*;

  logic             hold_v_r, hold_v_nxt;
  logic [RES_W-1:0] res_r;
  logic             open_r;
  logic             short_r;
  logic             accept;
  logic [STORED_ENTRIES-1:0] ge;
  logic [SEG_W-1:0] seg;

  assign in_ch.ready = !hold_v_r || push_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push_valid  = hold_v_r;

  always_comb begin
    hold_v_nxt = hold_v_r;
    if (accept) begin
      hold_v_nxt = 1'b1;
    end else if (push_ready) begin
      hold_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r   <= in_ch.resistance_milliohm;
      open_r  <= in_ch.line_open_fault;
      short_r <= in_ch.line_short_fault;
    end
  end

  // Descending table: entries at or above r form a run from index 0;
  // the segment is where that run ends.
  always_comb begin
    for (int j = 0; j < STORED_ENTRIES; j++) begin
      ge[j] = (j < USED_ENTRIES) && (res_r <= OHM_TABLE[j]);
    end
  end

  always_comb begin
    seg = '0;
    for (int j = 0; j < STORED_ENTRIES - 1; j++) begin
      if (ge[j] && !ge[j+1]) begin
        seg = seg | SEG_W'(j);
      end
    end
  end

  always_comb begin
    push_entry.resistance = res_r;
    push_entry.seg        = seg;
    if (open_r || res_r >= OHM_TABLE[0]) begin
      push_entry.cls = CLS_COLD;
    end else if (short_r || res_r <= OHM_TABLE[USED_ENTRIES-1]) begin
      push_entry.cls = CLS_HOT;
    end else begin
      push_entry.cls = CLS_INTERP;
    end
  end

endmodule

### sv/ntcrt_queue.sv
// ----------------------------------------------------------------------------
// ntcrt_queue
// Small register FIFO between classification and interpolation.
// ----------------------------------------------------------------------------
module ntcrt_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ntcrt_pkg::q_entry_t push_entry,
  input  logic                pop,
  output ntcrt_pkg::q_entry_t head,
  output ntcrt_pkg::q_stat_t  stat
);
  import ntcrt_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t         slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

### sv/ntcrt_back.sv
// ----------------------------------------------------------------------------
// ntcrt_back
// Interpolation engine: one multiply, then a restoring divider that yields
// one quotient bit per cycle, and the output register.
// ----------------------------------------------------------------------------
module ntcrt_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ntcrt_pkg::q_entry_t head,
  input  ntcrt_pkg::q_stat_t  stat,
  output logic                pop,
  ntcrt_out_if.source         out_ch
);
  import ntcrt_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W);

  bk_state_t state_r, state_nxt;
  logic                     out_v_r, out_v_nxt;
  logic signed [TEMP_W-1:0] out_temp_r;
  logic signed [TEMP_W-1:0] res_r;
  logic [SEG_W-1:0]         seg_r;
  logic [RES_W-1:0]         r_r;
  logic [REM_W-1:0]         rem_r;
  logic [REM_W-1:0]         den_sh_r;
  logic [QUOT_W-1:0]        q_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     out_load;
  logic                     div_last;

  logic [RES_W-1:0]         diff;
  logic [RES_W-1:0]         span;
  logic [DT_W-1:0]          dt;
  logic [PROD_W-1:0]        prod;
  logic                     q_bit;
  logic [QUOT_W-1:0]        q_nxt;
  logic signed [TEMP_W-1:0] sum;

  assign div_last = (cnt_r == CNT_W'(QUOT_W - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!stat.empty) begin
          state_nxt = (head.cls == CLS_INTERP) ? BK_MUL : BK_OUT;
        end
      end
      BK_MUL:  state_nxt = BK_DIV;
      BK_DIV: begin
        if (div_last) begin
          state_nxt = BK_OUT;
        end
      end
      BK_OUT: begin
        if (!out_v_r || out_ch.ready) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    case (state_r)
      BK_IDLE: pop = !stat.empty;
      BK_OUT:  out_load = !out_v_r || out_ch.ready;
      default: begin
        pop      = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (out_load) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  assign out_ch.valid                  = out_v_r;
  assign out_ch.temperature_decidegree = out_temp_r;

  // Datapath
  assign diff  = OHM_TABLE[seg_r] - r_r;
  assign span  = OHM_TABLE[seg_r] - OHM_TABLE[seg_r + 1'b1];
  assign dt    = DT_W'($unsigned(TEMP_TABLE[seg_r + 1'b1] - TEMP_TABLE[seg_r]));
  assign prod  = PROD_W'(diff) * PROD_W'(dt);
  assign q_bit = (rem_r >= den_sh_r);
  assign q_nxt = {q_r[QUOT_W-2:0], q_bit};
  assign sum   = TEMP_TABLE[seg_r] + $signed(TEMP_W'(q_nxt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      out_v_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
      if (state_r == BK_DIV) begin
        cnt_r <= div_last ? '0 : cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        if (!stat.empty) begin
          seg_r <= head.seg;
          r_r   <= head.resistance;
          res_r <= (head.cls == CLS_COLD) ? TEMP_COLD : TEMP_HOT;
        end
      end
      BK_MUL: begin
        // Round half up: (2*num + d) / (2*d)
        rem_r    <= REM_W'({prod, 1'b0}) + REM_W'(span);
        den_sh_r <= REM_W'({span, 1'b0}) << (QUOT_W - 1);
        q_r      <= '0;
      end
      BK_DIV: begin
        if (q_bit) begin
          rem_r <= rem_r - den_sh_r;
        end
        den_sh_r <= den_sh_r >> 1;
        q_r      <= q_nxt;
        if (div_last) begin
          res_r <= (sum > TEMP_HOT) ? TEMP_HOT : sum;
        end
      end
      default: begin
        if (out_load) begin
          out_temp_r <= res_r;
        end
      end
    endcase
  end

endmodule

### sv/ntc_resistance_to_temperature.sv
// ----------------------------------------------------------------------------
// ntc_resistance_to_temperature
// NTC thermistor resistance (milliohm) to temperature (0.1 degree) converter.
// ----------------------------------------------------------------------------
// Each sample gives one temperature. An open fault, or a resistance at or
// above the first table entry, reads -400; a short fault, or a resistance at
// or below the last used entry, reads 1200; otherwise the value is linearly
// interpolated in a 5-degree table and rounded half up. The front stage
// registers a sample and classifies it from that register, and a four-entry
// queue feeds the interpolation engine. Fault and out-of-range samples pass
// the engine's idle and output states; an interpolated sample also passes a
// multiply state and the bit-serial divider (one quotient bit per cycle).
// The engine finishes one sample before taking the next; the front accepts
// while it works or a result waits, until its register and the queue fill.
// TABLE_ENTRIES selects how many table entries are used (clamped to 2..33).
module ntc_resistance_to_temperature #(
  parameter int TABLE_ENTRIES = 33
) (
  input  logic         clk,
  input  logic         rst_n,
  ntcrt_in_if.sink     in_ch,
  ntcrt_out_if.source  out_ch
);
  import ntcrt_pkg::*;

  localparam int USED_ENTRIES = (TABLE_ENTRIES < 2) ? 2 :
                                (TABLE_ENTRIES > STORED_ENTRIES) ? STORED_ENTRIES :
                                TABLE_ENTRIES;

  logic     push_valid;
  logic     push_ready;
  q_entry_t push_entry;
  q_entry_t head;
  q_stat_t  stat;
  logic     pop;

  assign push_ready = !stat.full;

  ntcrt_front #(
    .USED_ENTRIES (USED_ENTRIES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  ntcrt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (stat)
  );

  ntcrt_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .stat   (stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

  a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(stat.full && stat.empty))
    else $error("queue reports full and empty at once");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("engine pops an empty queue");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.temperature_decidegree >= TEMP_COLD &&
                      out_ch.temperature_decidegree <= TEMP_HOT))
    else $error("temperature out of range");

  a_push_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && stat.full) |=> push_valid)
    else $error("front dropped a classified transaction");

endmodule

### verif/ntc_resistance_to_temperature_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ntc_resistance_to_temperature_test
// Drives thermistor samples into the converter with random gaps and output
// stalls. An in-house predictor computes the expected temperature of every
// accepted sample. A scoreboard checks the results in order.
// ----------------------------------------------------------------------------
module ntc_resistance_to_temperature_test;

  localparam int          ENTRIES      = 33;
  localparam int          COLD_DECIDEG = -400;
  localparam int          HOT_DECIDEG  = 1200;
  localparam int          STEP_DECIDEG = 50;
  localparam int          RANDOM_ITEMS = 1026;
  localparam int          SETTLE_CYCLES = 40;

  // Resistance in milliohms at -40.0, -35.0, ... +120.0 degrees
  localparam int unsigned SENSOR_MOHM [ENTRIES] = '{
    400000000, 260000000, 190000000, 150000000, 110000000,
    75000000,  56000000,  43000000,  33000000,  26000000,
    20000000,  16000000,  13000000,  10000000,  8200000,
    6500000,   5400000,   4300000,   3600000,   3000000,
    2500000,   2000000,   1800000,   1600000,   1300000,
    1000000,   920000,    780000,    650000,    570000,
    490000,    430000,    380000
  };

  typedef struct {
    logic [31:0] mohm;
    logic        open_f;
    logic        short_f;
  } sample_t;

  class temperature_scoreboard;
    logic signed [11:0] expected_temps[$];
    int                 failures;

    function new();
      failures = 0;
    endfunction

    function logic signed [11:0] thermistor_decidegree(sample_t s);
      logic [63:0] span;
      logic [63:0] offset;
      logic [63:0] frac;
      int          seg;
      if (s.open_f || s.mohm >= SENSOR_MOHM[0]) return 12'(COLD_DECIDEG);
      if (s.short_f || s.mohm <= SENSOR_MOHM[ENTRIES-1]) return 12'(HOT_DECIDEG);
      seg = 0;
      for (int i = 0; i < ENTRIES - 1; i++) begin
        if (s.mohm <= SENSOR_MOHM[i] && s.mohm > SENSOR_MOHM[i+1]) begin
          seg = i;
          break;
        end
      end
      span   = 64'(SENSOR_MOHM[seg]) - 64'(SENSOR_MOHM[seg+1]);
      offset = (64'(SENSOR_MOHM[seg]) - 64'(s.mohm)) * 64'(STEP_DECIDEG);
      // round half up: floor((2*offset + span) / (2*span))
      frac   = (2 * offset + span) / (2 * span);
      return 12'(COLD_DECIDEG + STEP_DECIDEG * seg + int'(frac));
    endfunction

    function void note_sample(sample_t s);
      expected_temps.push_back(thermistor_decidegree(s));
    endfunction

    function void check_temp(logic signed [11:0] got);
      logic signed [11:0] want;
      if (expected_temps.size() == 0) begin
        failures++;
        $display("%0t: unexpected temperature %0d, none outstanding", $time, got);
        return;
      end
      want = expected_temps.pop_front();
      if (got !== want) begin
        failures++;
        $display("%0t: temperature_decidegree expected %0d got %0d", $time, want, got);
      end
    endfunction

    function int outstanding();
      return expected_temps.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   feed_calm;
  bit   feed_done;
  temperature_scoreboard temp_sb;

  ntcrt_in_if  in_ch ();
  ntcrt_out_if out_ch ();

  ntc_resistance_to_temperature u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic sample_t make_sample(logic [31:0] mohm, logic open_f, logic short_f);
    sample_t s;
    s.mohm    = mohm;
    s.open_f  = open_f;
    s.short_f = short_f;
    return s;
  endfunction

  // Mostly in-range readings spread over every segment, plus edges and noise
  function automatic sample_t random_sample();
    sample_t     s;
    int unsigned pick;
    int unsigned seg;
    pick      = $urandom_range(99, 0);
    seg       = $urandom_range(ENTRIES - 2, 0);
    s.open_f  = ($urandom_range(19, 0) == 0);
    s.short_f = ($urandom_range(19, 0) == 0);
    if (pick < 70)
      s.mohm = $urandom_range(SENSOR_MOHM[seg], SENSOR_MOHM[seg+1] + 1);
    else if (pick < 80)
      s.mohm = SENSOR_MOHM[$urandom_range(ENTRIES - 1, 0)] + $urandom_range(4, 0) - 2;
    else if (pick < 90)
      s.mohm = $urandom();
    else if (pick < 95)
      s.mohm = $urandom_range(SENSOR_MOHM[ENTRIES-1], 0);
    else
      s.mohm = $urandom_range(32'hFFFF_FFFF, SENSOR_MOHM[0]);
    return s;
  endfunction

  task automatic push_sample(sample_t s);
    int unsigned gap;
    gap = feed_calm ? 0 : $urandom_range(14, 0);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid               = 1'b1;
    in_ch.resistance_milliohm = s.mohm;
    in_ch.line_open_fault     = s.open_f;
    in_ch.line_short_fault    = s.short_f;
    do @(posedge clk); while (!in_ch.ready);
    temp_sb.note_sample(s);
    @(negedge clk);
  endtask

  task automatic feed_samples();
    sample_t directed[$];
    directed.push_back(make_sample(32'd0, 1'b0, 1'b0));
    directed.push_back(make_sample(32'hFFFF_FFFF, 1'b0, 1'b0));
    directed.push_back(make_sample(32'd400000000, 1'b0, 1'b0));
    directed.push_back(make_sample(32'd399999999, 1'b0, 1'b0));
    // exact half step in the coldest and the hottest segment: rounds up
    directed.push_back(make_sample(32'd398600000, 1'b0, 1'b0));
    directed.push_back(make_sample(32'd429500, 1'b0, 1'b0));
    directed.push_back(make_sample(32'd260000001, 1'b0, 1'b0));
    directed.push_back(make_sample(32'd260000000, 1'b0, 1'b0));
    directed.push_back(make_sample(32'd259999999, 1'b0, 1'b0));
    directed.push_back(make_sample(32'd1000000, 1'b0, 1'b0));
    directed.push_back(make_sample(32'd999999, 1'b0, 1'b0));
    directed.push_back(make_sample(32'd920001, 1'b0, 1'b0));
    directed.push_back(make_sample(32'd25000000, 1'b0, 1'b0));
    directed.push_back(make_sample(32'd381000, 1'b0, 1'b0));
    directed.push_back(make_sample(32'd380001, 1'b0, 1'b0));
    directed.push_back(make_sample(32'd380000, 1'b0, 1'b0));
    directed.push_back(make_sample(32'd379999, 1'b0, 1'b0));
    // wiring faults; open wins over short
    directed.push_back(make_sample(32'd25000000, 1'b1, 1'b0));
    directed.push_back(make_sample(32'd25000000, 1'b0, 1'b1));
    directed.push_back(make_sample(32'd25000000, 1'b1, 1'b1));
    directed.push_back(make_sample(32'd0, 1'b1, 1'b0));
    directed.push_back(make_sample(32'hFFFF_FFFF, 1'b0, 1'b1));
    directed.push_back(make_sample(32'd0, 1'b1, 1'b1));
    feed_calm = 1'b0;
    foreach (directed[k]) push_sample(directed[k]);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) feed_calm = ($urandom_range(3, 0) == 0);
      push_sample(random_sample());
    end
    in_ch.valid = 1'b0;
    feed_done   = 1'b1;
  endtask

  task automatic drain_results();
    int unsigned stall;
    int          taken;
    bit          drain_calm;
    taken      = 0;
    drain_calm = 1'b0;
    forever begin
      if (taken % 40 == 0) drain_calm = ($urandom_range(3, 0) == 0);
      stall = drain_calm ? 0 : $urandom_range(14, 0);
      if (stall != 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      temp_sb.check_temp(out_ch.temperature_decidegree);
      taken++;
      @(negedge clk);
    end
  endtask

  initial begin
    temp_sb                   = new();
    feed_done                 = 1'b0;
    rst_n                     = 1'b0;
    in_ch.valid               = 1'b0;
    in_ch.resistance_milliohm = '0;
    in_ch.line_open_fault     = 1'b0;
    in_ch.line_short_fault    = 1'b0;
    out_ch.ready              = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    fork
      feed_samples();
      drain_results();
    join_none
    wait (feed_done);
    while (temp_sb.outstanding() != 0) @(posedge clk);
    // catch any stray transaction after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (temp_sb.failures == 0)
      $display("ntc_resistance_to_temperature verification clean");
    else
      $display("ntc_resistance_to_temperature verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("ntc_resistance_to_temperature verification failed");
    $finish;
  end

endmodule

### sim.f
sv/ntcrt_pkg.sv
sv/ntcrt_in_if.sv
sv/ntcrt_out_if.sv
sv/ntcrt_front.sv
sv/ntcrt_queue.sv
sv/ntcrt_back.sv
sv/ntc_resistance_to_temperature.sv
verif/ntc_resistance_to_temperature_test.sv
